[rtl/assert_macros.svh]
// assertion macros used by the byte serializer
// each expects signals named clock and reset in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CHK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

[rtl/mbrtu_pkg.sv]
// shared types, constants and the byte-wide crc-16 update for the request framer
// no dependencies
`timescale 1ns / 1ps

package mbrtu_pkg;

   localparam int FrameLen  = 8;
   localparam int HeaderLen = 6;
   localparam int IdxWidth  = $clog2(FrameLen);
   localparam int HdrWidth  = HeaderLen * 8;

   localparam logic [15:0] CrcInit = 16'hFFFF;
   localparam logic [15:0] CrcPoly = 16'hA001;

   // byte positions of the crc within the frame
   localparam logic [IdxWidth-1:0] IdxCrcLo = IdxWidth'(HeaderLen);
   localparam logic [IdxWidth-1:0] IdxCrcHi = IdxWidth'(FrameLen - 1);

   typedef struct packed {
      logic [7:0]  slave_address;
      logic [7:0]  function_code;
      logic [15:0] register_address;
      logic [15:0] register_value;
   } req_type;

   // one byte through the reflected crc, lsb first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int b = 0; b < 8; b++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CrcPoly;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

[rtl/mbrtu_serializer.sv]
// byte serializer: shifts out the six header bytes while folding them into the crc,
// then sends the crc low and high bytes; uses mbrtu_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mbrtu_serializer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load_valid,
   input  mbrtu_pkg::req_type   load_data,
   output logic                 load_take,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_frame_byte,
   output logic                 rsp_last_byte
);

   logic                              busy_ff, busy_in;
   logic [mbrtu_pkg::IdxWidth-1:0]    idx_ff, idx_in;
   logic [mbrtu_pkg::HdrWidth-1:0]    data_ff, data_in;
   logic [15:0]                       crc_ff, crc_in;
   logic                              fire;
   logic                              at_last;
   logic                              free;

   assign fire      = busy_ff && rsp_ready;
   assign at_last   = (idx_ff == mbrtu_pkg::IdxCrcHi);
   assign free      = !busy_ff || (fire && at_last);
   assign load_take = free && load_valid;

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      data_in = data_ff;
      crc_in  = crc_ff;
      if (fire) begin
         idx_in = idx_ff + 1'b1;
         if (idx_ff < mbrtu_pkg::IdxCrcLo) begin
            // header byte leaves: fold it into the running crc
            crc_in  = mbrtu_pkg::crc_byte(crc_ff, data_ff[mbrtu_pkg::HdrWidth-1 -: 8]);
            data_in = {data_ff[mbrtu_pkg::HdrWidth-9:0], 8'h00};
         end
         if (at_last) begin
            busy_in = 1'b0;
         end
      end
      if (load_take) begin
         busy_in = 1'b1;
         idx_in  = '0;
         data_in = {load_data.slave_address, load_data.function_code,
                    load_data.register_address, load_data.register_value};
         crc_in  = mbrtu_pkg::CrcInit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
      data_ff <= data_in;
      crc_ff  <= crc_in;
   end

   always_comb begin
      case (idx_ff)
         mbrtu_pkg::IdxCrcLo: rsp_frame_byte = crc_ff[7:0];
         mbrtu_pkg::IdxCrcHi: rsp_frame_byte = crc_ff[15:8];
         default:             rsp_frame_byte = data_ff[mbrtu_pkg::HdrWidth-1 -: 8];
      endcase
   end

   assign rsp_valid     = busy_ff;
   assign rsp_last_byte = at_last;

   `ASSERT_CHK(a_frame_continues, fire && !at_last |=> busy_ff, "frame stopped before its last byte")
   `ASSERT_CHK(a_idx_steps, fire && !at_last && !load_take |=> idx_ff == $past(idx_ff) + 1'b1, "byte index skipped")
   `ASSERT_NEVER(a_load_overrun, load_take && busy_ff && !(fire && at_last), "new request loaded over a running frame")
   `ASSERT_CHK(a_load_starts, load_take |=> busy_ff && idx_ff == '0 && crc_ff == mbrtu_pkg::CrcInit, "frame did not start cleanly")

endmodule

[rtl/modbus_rtu_request_framer.sv]
// channel  | signals                                            | direction
// ---------+----------------------------------------------------+----------
// request  | req_valid/req_ready, slave/function/address/value  | in
// response | rsp_valid/rsp_ready, rsp_frame_byte, rsp_last_byte | out
//
// each request yields eight bytes, one per cycle while rsp_ready is high.
// a one-deep request register takes the next request while a frame is going out;
// a held request's frame follows its predecessor's last byte with no gap.
// reset (synchronous) drops any held request and any frame in progress.
// a low rsp_ready holds the current byte; the request side stalls once its register is full.
// uses mbrtu_pkg and mbrtu_serializer
`timescale 1ns / 1ps

module modbus_rtu_request_framer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_slave_address,
   input  logic [7:0]  req_function_code,
   input  logic [15:0] req_register_address,
   input  logic [15:0] req_register_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_frame_byte,
   output logic        rsp_last_byte
);

   logic                hold_valid_ff, hold_valid_in;
   mbrtu_pkg::req_type  hold_ff, hold_in;
   logic                req_fire;
   logic                load_take;

   assign req_ready = !hold_valid_ff;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      if (load_take) begin
         hold_valid_in = 1'b0;
      end
      if (req_fire) begin
         hold_valid_in            = 1'b1;
         hold_in.slave_address    = req_slave_address;
         hold_in.function_code    = req_function_code;
         hold_in.register_address = req_register_address;
         hold_in.register_value   = req_register_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_ff <= hold_in;
   end

   mbrtu_serializer u_serializer (
      .clock          (clock),
      .reset          (reset),
      .load_valid     (hold_valid_ff),
      .load_data      (hold_ff),
      .load_take      (load_take),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_last_byte  (rsp_last_byte)
   );

endmodule
